// ===== sv/array_binary_search_tree_assert.svh =====
// Assertion macros for the search tree engine.
`ifndef ARRAY_BINARY_SEARCH_TREE_ASSERT_SVH
`define ARRAY_BINARY_SEARCH_TREE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ABST_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ABST_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/abst_pkg.sv =====
package abst_pkg;

	localparam int NODE_SLOTS = 64;
	localparam int SLOT_W = $clog2(NODE_SLOTS);
	localparam int LINK_W = $clog2(NODE_SLOTS + 1);

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [LINK_W-1:0] link_t;

	localparam link_t LINK_NONE = link_t'(NODE_SLOTS);

	typedef struct packed {
		logic signed [31:0] key;
		link_t              par;
		link_t              lft;
		link_t              rgt;
	} node_t;

	localparam node_t NODE_RESET = '{key: 32'sd0, par: LINK_NONE, lft: LINK_NONE,
		rgt: LINK_NONE};

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_DELETE = 3'd1,
		OP_SEARCH = 3'd2,
		OP_MIN    = 3'd3,
		OP_MAX    = 3'd4,
		OP_SUCC   = 3'd5
	} op_t;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_EMPTY_TREE = 3'd1;
	localparam logic [2:0] ST_NEG_KEY    = 3'd2;
	localparam logic [2:0] ST_POOL_FULL  = 3'd3;
	localparam logic [2:0] ST_SLOT_EMPTY = 3'd4;

	typedef struct packed {
		logic  rd_en;
		slot_t rd_addr;
		logic  wr_en;
		slot_t wr_addr;
		node_t wr_data;
	} ram_req_t;

	typedef struct packed {
		logic  set_en;
		logic  clr_en;
		slot_t idx;
		logic  rd_en;
		slot_t rd_addr;
	} map_req_t;

	typedef struct packed {
		logic  rd_used;
		logic  full;
		slot_t free_idx;
	} map_rsp_t;

	typedef struct packed {
		logic [2:0] status;
		link_t      idx;
		logic       found;
	} res_t;

	function automatic logic is_slot(link_t l);
		return l < LINK_NONE;
	endfunction

endpackage

// ===== sv/abst_node_ram.sv =====
module abst_node_ram (
	input  logic              clk,
	input  abst_pkg::ram_req_t req,
	output abst_pkg::node_t    rd_data
);

	abst_pkg::node_t mem [abst_pkg::NODE_SLOTS];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

// ===== sv/abst_slot_map.sv =====
module abst_slot_map (
	input  logic               clk,
	input  logic               arst_n,
	input  abst_pkg::map_req_t req,
	output abst_pkg::map_rsp_t rsp
);

	logic [abst_pkg::NODE_SLOTS-1:0] used_q;
	logic                            rd_used_q;
	abst_pkg::slot_t                 free_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			rd_used_q <= 1'b0;
		end else begin
			if (req.set_en) begin
				used_q[req.idx] <= 1'b1;
			end
			if (req.clr_en) begin
				used_q[req.idx] <= 1'b0;
			end
			if (req.rd_en) begin
				rd_used_q <= used_q[req.rd_addr];
			end
		end
	end

	// lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = abst_pkg::NODE_SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_idx = abst_pkg::slot_t'(i);
			end
		end
	end

	assign rsp.rd_used  = rd_used_q;
	assign rsp.full     = &used_q;
	assign rsp.free_idx = free_idx;

endmodule

// ===== sv/abst_ctrl.sv =====
module abst_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic [2:0]         operation,
	input  logic signed [31:0] key,
	input  logic [5:0]         slot_index,
	output logic               busy,
	input  abst_pkg::node_t    ram_q,
	output abst_pkg::ram_req_t ram_req,
	output abst_pkg::map_req_t map_req,
	input  abst_pkg::map_rsp_t map_rsp,
	input  logic               res_take,
	output logic               res_valid,
	output abst_pkg::res_t     res
);

	typedef enum logic [17:0] {
		S_IDLE      = 18'h00001,
		S_INS_WALK  = 18'h00002,
		S_INS_NEW   = 18'h00004,
		S_INS_LINK  = 18'h00008,
		S_DEL_Z     = 18'h00010,
		S_DEL_X     = 18'h00020,
		S_DEL_XW    = 18'h00040,
		S_DEL_P     = 18'h00080,
		S_DEL_PW    = 18'h00100,
		S_DEL_K     = 18'h00200,
		S_DEL_KW    = 18'h00400,
		S_DEL_FREE  = 18'h00800,
		S_SRCH_WALK = 18'h01000,
		S_SRCH_CHK  = 18'h02000,
		S_EXT_WALK  = 18'h04000,
		S_SUC_Z     = 18'h08000,
		S_SUC_UP    = 18'h10000,
		S_DONE      = 18'h20000
	} state_t;

	state_t                state_q, state_d;
	logic signed [31:0]    key_q, key_d;
	abst_pkg::link_t       slot_q, slot_d;
	abst_pkg::link_t       cur_q, cur_d;
	abst_pkg::link_t       p_q, p_d;
	abst_pkg::link_t       n_q, n_d;
	abst_pkg::link_t       free_q, free_d;
	abst_pkg::link_t       y_q, y_d;
	abst_pkg::link_t       x_q, x_d;
	abst_pkg::link_t       root_q, root_d;
	abst_pkg::node_t       ynode_q, ynode_d;
	abst_pkg::node_t       pnode_q, pnode_d;
	logic                  dir_q, dir_d;
	logic                  ext_del_q, ext_del_d;
	abst_pkg::res_t        res_q, res_d;

	abst_pkg::node_t       rnode;
	abst_pkg::node_t       wnode;
	abst_pkg::link_t       n_next;
	abst_pkg::link_t       nxt;
	abst_pkg::link_t       ext_link;
	abst_pkg::link_t       x_c;
	logic                  slot_ok;

	// entries never written or freed read as reset nodes
	assign rnode    = map_rsp.rd_used ? ram_q : abst_pkg::NODE_RESET;
	assign n_next   = n_q + 1'b1;
	assign nxt      = (key_q < rnode.key) ? rnode.lft : rnode.rgt;
	assign ext_link = dir_q ? rnode.rgt : rnode.lft;
	assign x_c      = abst_pkg::is_slot(ynode_q.lft) ? ynode_q.lft : ynode_q.rgt;
	assign slot_ok  = int'(slot_index) < abst_pkg::NODE_SLOTS;

	always_comb begin
		state_d   = state_q;
		key_d     = key_q;
		slot_d    = slot_q;
		cur_d     = cur_q;
		p_d       = p_q;
		n_d       = n_q;
		free_d    = free_q;
		y_d       = y_q;
		x_d       = x_q;
		root_d    = root_q;
		ynode_d   = ynode_q;
		pnode_d   = pnode_q;
		dir_d     = dir_q;
		ext_del_d = ext_del_q;
		res_d     = res_q;
		wnode     = rnode;
		ram_req   = '0;
		map_req   = '0;

		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					key_d  = key;
					slot_d = abst_pkg::link_t'(slot_index);
					n_d    = '0;
					res_d  = '{status: abst_pkg::ST_OK, idx: '0, found: 1'b0};
					state_d = S_DONE;
					case (operation)
						abst_pkg::OP_INSERT: begin
							if (key < 0) begin
								res_d.status = abst_pkg::ST_NEG_KEY;
							end else if (map_rsp.full) begin
								res_d.status = abst_pkg::ST_POOL_FULL;
							end else begin
								free_d = abst_pkg::link_t'(map_rsp.free_idx);
								p_d    = abst_pkg::LINK_NONE;
								if (abst_pkg::is_slot(root_q)) begin
									cur_d           = root_q;
									ram_req.rd_en   = 1'b1;
									ram_req.rd_addr = abst_pkg::slot_t'(root_q);
									state_d         = S_INS_WALK;
								end else begin
									state_d = S_INS_NEW;
								end
							end
						end
						abst_pkg::OP_DELETE, abst_pkg::OP_SUCC: begin
							if (!slot_ok) begin
								res_d.status = abst_pkg::ST_SLOT_EMPTY;
							end else begin
								ram_req.rd_en   = 1'b1;
								ram_req.rd_addr = abst_pkg::slot_t'(slot_index);
								state_d = (operation == abst_pkg::OP_DELETE) ? S_DEL_Z
									: S_SUC_Z;
							end
						end
						abst_pkg::OP_SEARCH, abst_pkg::OP_MIN, abst_pkg::OP_MAX: begin
							if (!abst_pkg::is_slot(root_q)) begin
								res_d.status = abst_pkg::ST_EMPTY_TREE;
							end else begin
								cur_d           = root_q;
								ram_req.rd_en   = 1'b1;
								ram_req.rd_addr = abst_pkg::slot_t'(root_q);
								dir_d           = (operation == abst_pkg::OP_MAX);
								ext_del_d       = 1'b0;
								state_d = (operation == abst_pkg::OP_SEARCH) ? S_SRCH_WALK
									: S_EXT_WALK;
							end
						end
						default: ;
					endcase
				end
			end

			S_INS_WALK: begin
				p_d     = cur_q;
				pnode_d = rnode;
				n_d     = n_next;
				if (n_next < abst_pkg::LINK_NONE && abst_pkg::is_slot(nxt)) begin
					cur_d           = nxt;
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = abst_pkg::slot_t'(nxt);
				end else begin
					state_d = S_INS_NEW;
				end
			end

			S_INS_NEW: begin
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = abst_pkg::slot_t'(free_q);
				ram_req.wr_data = '{key: key_q, par: p_q, lft: abst_pkg::LINK_NONE,
					rgt: abst_pkg::LINK_NONE};
				map_req.set_en  = 1'b1;
				map_req.idx     = abst_pkg::slot_t'(free_q);
				res_d.idx       = free_q;
				res_d.found     = 1'b1;
				if (abst_pkg::is_slot(p_q)) begin
					state_d = S_INS_LINK;
				end else begin
					root_d  = free_q;
					state_d = S_DONE;
				end
			end

			S_INS_LINK: begin
				wnode = pnode_q;
				if (key_q < pnode_q.key) begin
					wnode.lft = free_q;
				end else begin
					wnode.rgt = free_q;
				end
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = abst_pkg::slot_t'(p_q);
				ram_req.wr_data = wnode;
				state_d         = S_DONE;
			end

			S_DEL_Z: begin
				if (!map_rsp.rd_used) begin
					res_d.status = abst_pkg::ST_SLOT_EMPTY;
					state_d      = S_DONE;
				end else if (!abst_pkg::is_slot(rnode.lft) || !abst_pkg::is_slot(rnode.rgt))
				begin
					y_d     = slot_q;
					ynode_d = rnode;
					state_d = S_DEL_X;
				end else begin
					cur_d           = rnode.rgt;
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = abst_pkg::slot_t'(rnode.rgt);
					dir_d           = 1'b0;
					ext_del_d       = 1'b1;
					state_d         = S_EXT_WALK;
				end
			end

			S_DEL_X: begin
				x_d = x_c;
				if (abst_pkg::is_slot(x_c)) begin
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = abst_pkg::slot_t'(x_c);
					state_d         = S_DEL_XW;
				end else begin
					state_d = S_DEL_P;
				end
			end

			S_DEL_XW: begin
				wnode.par       = ynode_q.par;
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = abst_pkg::slot_t'(x_q);
				ram_req.wr_data = wnode;
				state_d         = S_DEL_P;
			end

			S_DEL_P: begin
				if (abst_pkg::is_slot(ynode_q.par)) begin
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = abst_pkg::slot_t'(ynode_q.par);
					state_d         = S_DEL_PW;
				end else begin
					root_d  = x_q;
					state_d = S_DEL_K;
				end
			end

			S_DEL_PW: begin
				if (rnode.lft == y_q) begin
					wnode.lft = x_q;
				end else begin
					wnode.rgt = x_q;
				end
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = abst_pkg::slot_t'(ynode_q.par);
				ram_req.wr_data = wnode;
				state_d         = S_DEL_K;
			end

			S_DEL_K: begin
				if (y_q != slot_q) begin
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = abst_pkg::slot_t'(slot_q);
					state_d         = S_DEL_KW;
				end else begin
					state_d = S_DEL_FREE;
				end
			end

			S_DEL_KW: begin
				wnode.key       = ynode_q.key;
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = abst_pkg::slot_t'(slot_q);
				ram_req.wr_data = wnode;
				state_d         = S_DEL_FREE;
			end

			S_DEL_FREE: begin
				map_req.clr_en = 1'b1;
				map_req.idx    = abst_pkg::slot_t'(y_q);
				res_d.idx      = y_q;
				res_d.found    = 1'b1;
				state_d        = S_DONE;
			end

			S_SRCH_WALK: begin
				n_d = n_next;
				if (rnode.key == key_q) begin
					res_d.idx   = cur_q;
					res_d.found = 1'b1;
					state_d     = S_DONE;
				end else if (abst_pkg::is_slot(nxt)) begin
					cur_d           = nxt;
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = abst_pkg::slot_t'(nxt);
					if (!(n_next < abst_pkg::LINK_NONE)) begin
						state_d = S_SRCH_CHK;
					end
				end else begin
					state_d = S_DONE;
				end
			end

			S_SRCH_CHK: begin
				if (rnode.key == key_q) begin
					res_d.idx   = cur_q;
					res_d.found = 1'b1;
				end
				state_d = S_DONE;
			end

			S_EXT_WALK: begin
				if (n_q < abst_pkg::LINK_NONE && abst_pkg::is_slot(ext_link)) begin
					cur_d           = ext_link;
					n_d             = n_next;
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = abst_pkg::slot_t'(ext_link);
				end else if (ext_del_q) begin
					y_d     = cur_q;
					ynode_d = rnode;
					state_d = S_DEL_X;
				end else begin
					res_d.idx   = cur_q;
					res_d.found = 1'b1;
					state_d     = S_DONE;
				end
			end

			S_SUC_Z: begin
				if (!map_rsp.rd_used) begin
					res_d.status = abst_pkg::ST_SLOT_EMPTY;
					state_d      = S_DONE;
				end else if (abst_pkg::is_slot(rnode.rgt)) begin
					cur_d           = rnode.rgt;
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = abst_pkg::slot_t'(rnode.rgt);
					dir_d           = 1'b0;
					ext_del_d       = 1'b0;
					state_d         = S_EXT_WALK;
				end else begin
					cur_d = slot_q;
					p_d   = rnode.par;
					if (abst_pkg::is_slot(rnode.par)) begin
						ram_req.rd_en   = 1'b1;
						ram_req.rd_addr = abst_pkg::slot_t'(rnode.par);
						state_d         = S_SUC_UP;
					end else begin
						state_d = S_DONE;
					end
				end
			end

			S_SUC_UP: begin
				if (rnode.rgt == cur_q) begin
					cur_d = p_q;
					p_d   = rnode.par;
					n_d   = n_next;
					if (n_next < abst_pkg::LINK_NONE && abst_pkg::is_slot(rnode.par)) begin
						ram_req.rd_en   = 1'b1;
						ram_req.rd_addr = abst_pkg::slot_t'(rnode.par);
					end else begin
						if (abst_pkg::is_slot(rnode.par)) begin
							res_d.idx   = rnode.par;
							res_d.found = 1'b1;
						end
						state_d = S_DONE;
					end
				end else begin
					res_d.idx   = p_q;
					res_d.found = 1'b1;
					state_d     = S_DONE;
				end
			end

			S_DONE: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end

			default: state_d = S_IDLE;
		endcase

		map_req.rd_en   = ram_req.rd_en;
		map_req.rd_addr = ram_req.rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			root_q  <= abst_pkg::LINK_NONE;
		end else begin
			state_q <= state_d;
			root_q  <= root_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q     <= key_d;
		slot_q    <= slot_d;
		cur_q     <= cur_d;
		p_q       <= p_d;
		n_q       <= n_d;
		free_q    <= free_d;
		y_q       <= y_d;
		x_q       <= x_d;
		ynode_q   <= ynode_d;
		pnode_q   <= pnode_d;
		dir_q     <= dir_d;
		ext_del_q <= ext_del_d;
		res_q     <= res_d;
	end

	assign busy      = (state_q != S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

endmodule

// ===== sv/array_binary_search_tree.sv =====
// Binary search tree engine over a pool of 64 node slots.
// Request channel (req_valid / req_stall): operation, key, slot_index. A transfer
// happens on a rising edge with req_valid high and req_stall low. Operations:
// insert, delete by slot, search, minimum, maximum, in-order successor.
// Response channel (rsp_valid / rsp_stall): status, result_index, found, one
// response per request, in order.
// Timing: one operation at a time. The time a request takes grows with the number
// of nodes walked, plus the delete write-backs. Every link step is one read of the
// node memory, whose single registered read port sets the pace.
// A finished response sits in the output register; a new request is taken while
// it waits, but the next response cannot leave the engine until it is taken, so
// a stalled receiver holds the engine in its final state and req_stall stays high.
// Reset: tree empty, all slots free; slot-use bits clear at once, so no clearing
// pass runs and requests are taken as soon as reset is released.
module array_binary_search_tree (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [2:0]         operation,
	input  logic signed [31:0] key,
	input  logic [5:0]         slot_index,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [2:0]         status,
	output logic [5:0]         result_index,
	output logic               found
);

	abst_pkg::ram_req_t ram_req;
	abst_pkg::node_t    ram_q;
	abst_pkg::map_req_t map_req;
	abst_pkg::map_rsp_t map_rsp;
	abst_pkg::res_t     res;
	logic               res_valid;
	logic               res_take;
	logic               busy;
	logic               rsp_valid_q;
	abst_pkg::res_t     rsp_q;

	// node links and keys
	abst_node_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (ram_q)
	);

	// slot-use bits and lowest-free-slot lookup
	abst_slot_map u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (map_req),
		.rsp    (map_rsp)
	);

	// operation sequencer
	abst_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.operation  (operation),
		.key        (key),
		.slot_index (slot_index),
		.busy       (busy),
		.ram_q      (ram_q),
		.ram_req    (ram_req),
		.map_req    (map_req),
		.map_rsp    (map_rsp),
		.res_take   (res_take),
		.res_valid  (res_valid),
		.res        (res)
	);

	assign req_stall = busy;

	// load the output register when it is empty or being drained this cycle
	assign res_take = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = rsp_q.status;
	assign result_index = 6'(rsp_q.idx);
	assign found        = rsp_q.found;

endmodule

// ===== sv/abst_checker.sv =====
`include "array_binary_search_tree_assert.svh"

module abst_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_stall,
	input logic       rsp_valid,
	input logic       rsp_stall,
	input logic [2:0] status,
	input logic [5:0] result_index,
	input logic       found
);

	// no slot to report means index zero
	`ABST_ASSERT_NOW(a_idx_zero, rsp_valid && !found, result_index == 6'd0, "index without slot")

	// a reported slot only comes with an ok status
	`ABST_ASSERT_NOW(a_found_ok, rsp_valid && found, status == abst_pkg::ST_OK, "slot on error")

	// engine is busy right after taking a request
	`ABST_ASSERT_NXT(a_busy, req_valid && !req_stall, req_stall, "no busy after transfer")

	// stalled response holds
	`ABST_ASSERT_NXT(a_hold, rsp_valid && rsp_stall,
		rsp_valid && $stable(status) && $stable(result_index) && $stable(found),
		"stalled response changed")

endmodule

bind array_binary_search_tree abst_checker u_abst_checker (.*);
